[hdl/assert_macros.svh]
// assertion macros used by the checker file
// depends on nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is low
`define CCEP_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");

`endif

[hdl/ccep_pkg.sv]
// shared types, codes and tables for the color cube edge palette unit
// depends on nothing
package ccep_pkg;

	localparam int LVL_W = 12;
	localparam int CNT_W = 13;
	localparam int IDX_W = 12;
	localparam int CFG_W = 13;

	localparam logic [11:0] NUM_EDGES   = 12'd5;
	localparam logic [12:0] SMALL_LIMIT = 13'd10;
	// 2^14 / 5 rounded up, exact quotient for any 12-bit dividend
	localparam logic [13:0] RECIP_EDGES = 14'd3277;
	localparam int          RECIP_SHIFT = 14;

	typedef enum logic [0:0] {
		REG_MAX_LEVEL  = 1'b0,
		REG_NUM_COLORS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		EDGE_RY = 3'd0,
		EDGE_YG = 3'd1,
		EDGE_GC = 3'd2,
		EDGE_CB = 3'd3,
		EDGE_BM = 3'd4
	} edge_t;

	typedef enum logic [2:0] {
		SU_KICK,
		SU_LONG,
		SU_SHORT,
		SU_EDGES,
		SU_IDLE
	} setup_state_t;

	typedef struct packed {
		logic [LVL_W-1:0] r;
		logic [LVL_W-1:0] g;
		logic [LVL_W-1:0] b;
	} rgb_t;

	// fixed colors for palettes under ten entries
	function automatic rgb_t small_color(input logic [3:0] idx);
		rgb_t c;
		case (idx)
			4'd0: c = '{12'd215, 12'd25, 12'd28};
			4'd1: c = '{12'd255, 12'd255, 12'd191};
			4'd2: c = '{12'd44, 12'd123, 12'd182};
			4'd3: c = '{12'd0, 12'd136, 12'd55};
			4'd4: c = '{12'd192, 12'd192, 12'd192};
			4'd5: c = '{12'd194, 12'd165, 12'd207};
			4'd6: c = '{12'd166, 12'd97, 12'd26};
			4'd7: c = '{12'd171, 12'd217, 12'd233};
			4'd8: c = '{12'd166, 12'd219, 12'd160};
			4'd9: c = '{12'd235, 12'd150, 12'd5};
			default: c = '{12'd0, 12'd0, 12'd0};
		endcase
		return c;
	endfunction

endpackage

[hdl/ccep_div.sv]
// iterative restoring divider, one quotient bit per cycle
// depends on ccep_pkg
module ccep_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [ccep_pkg::LVL_W-1:0] dividend,
	input  logic [ccep_pkg::LVL_W-1:0] divisor,
	output logic                      done,
	output logic [ccep_pkg::LVL_W-1:0] quo
);
	localparam int W = ccep_pkg::LVL_W;

	logic         run_q;
	logic         done_q;
	logic [3:0]   cnt_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] dsr_q;
	logic [W:0]   trial;
	logic         fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q  <= cnt_q + 4'd1;
			if (cnt_q == 4'(W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? W'(trial - {1'b0, dsr_q}) : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

[hdl/color_cube_edge_palette_unit.sv]
// top level of the color cube edge palette unit
// depends on ccep_pkg and ccep_div
//
// usage:
// - configuration: cfg_we with cfg_index (0 max_level, 1 num_colors) and cfg_data
//   writes a register at the clock edge. after reset and after every write the
//   unit derives segment lengths by a reciprocal multiply and step sizes with a
//   shared iterative divider (two 12-bit divisions); busy is high
//   during that time.
// - items: an index is taken at a rising edge with start high and busy low.
//   with busy low, one index can be taken every cycle.
// - results: red, green, blue and status appear for one cycle, marked by
//   result_valid, once the item has passed the stages. the receiver cannot stall,
//   so the four-stage pipeline never holds.
// - stages: range checks and edge search by compare, offset and step select,
//   multiply, corner compose into the output register.
// - reset: arst_n clears all valid bits and registers to max_level 255 and
//   num_colors 10, then the setup pass runs.
module color_cube_edge_palette_unit #(
	parameter int PALETTE_DEPTH = 4096,
	parameter int LEVEL_BITS    = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [ccep_pkg::IDX_W-1:0]  palette_index,
	output logic                        result_valid,
	output logic [ccep_pkg::LVL_W-1:0]  red,
	output logic [ccep_pkg::LVL_W-1:0]  green,
	output logic [ccep_pkg::LVL_W-1:0]  blue,
	output logic [1:0]                  status,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [ccep_pkg::CFG_W-1:0]  cfg_data
);
	localparam int W = ccep_pkg::LVL_W;
	localparam logic [W-1:0] LVL_MASK = (LEVEL_BITS >= W) ? {W{1'b1}} :
		W'((32'd1 << LEVEL_BITS) - 32'd1);

	logic [W-1:0]                 max_level_q;
	logic [ccep_pkg::CNT_W-1:0]   num_colors_q;
	logic [W-1:0]                 lvl;
	logic [ccep_pkg::CNT_W-1:0]   cnt;
	logic [W-1:0]                 span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q  <= 12'd255;
			num_colors_q <= 13'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				ccep_pkg::REG_MAX_LEVEL:  max_level_q  <= cfg_data[W-1:0];
				ccep_pkg::REG_NUM_COLORS: num_colors_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign lvl  = max_level_q & LVL_MASK;
	assign cnt  = (32'(num_colors_q) > 32'(PALETTE_DEPTH)) ?
		ccep_pkg::CNT_W'(PALETTE_DEPTH) : num_colors_q;
	assign span = (cnt == '0) ? '0 : W'(cnt - 13'd1);

	// setup sequencer: base and extra from span/5 by reciprocal, then the two step sizes
	ccep_pkg::setup_state_t su_q, su_d;
	logic         div_go;
	logic [W-1:0] div_a, div_b;
	logic         div_done;
	logic [W-1:0] div_quo;
	logic [W-1:0] base_q;
	logic [2:0]   extra_q;
	logic [W-1:0] step_long_q, step_short_q;
	logic [W-1:0] start_q [1:4];
	logic [W-1:0] base_n;
	logic [W+13:0] recip_prod;
	logic [W-1:0] base_c;
	logic [W-1:0] rem5;

	ccep_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quo      (div_quo)
	);

	assign recip_prod = span * ccep_pkg::RECIP_EDGES;
	assign base_c     = recip_prod[W+13:ccep_pkg::RECIP_SHIFT];
	assign rem5       = span - W'(base_c * ccep_pkg::NUM_EDGES);
	assign base_n     = (base_c == '0) ? W'(1) : base_c;

	always_comb begin
		su_d   = su_q;
		div_go = 1'b0;
		div_a  = lvl;
		div_b  = base_q;
		case (su_q)
			ccep_pkg::SU_KICK: begin
				div_go = 1'b1;
				div_b  = W'(base_n + W'(1));
				su_d   = ccep_pkg::SU_LONG;
			end
			ccep_pkg::SU_LONG: begin
				if (div_done) begin
					div_go = 1'b1;
					div_b  = base_q;
					su_d   = ccep_pkg::SU_SHORT;
				end
			end
			ccep_pkg::SU_SHORT: begin
				if (div_done) su_d = ccep_pkg::SU_EDGES;
			end
			ccep_pkg::SU_EDGES: su_d = ccep_pkg::SU_IDLE;
			ccep_pkg::SU_IDLE:  su_d = ccep_pkg::SU_IDLE;
			default:            su_d = ccep_pkg::SU_KICK;
		endcase
		if (cfg_we) begin
			su_d   = ccep_pkg::SU_KICK;
			div_go = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) su_q <= ccep_pkg::SU_KICK;
		else         su_q <= su_d;
	end

	always_ff @(posedge clk) begin
		if (su_q == ccep_pkg::SU_KICK) begin
			base_q  <= base_n;
			extra_q <= rem5[2:0];
		end
		if (su_q == ccep_pkg::SU_LONG && div_done) step_long_q <= div_quo;
		if (su_q == ccep_pkg::SU_SHORT && div_done) step_short_q <= div_quo;
		if (su_q == ccep_pkg::SU_EDGES) begin
			// edge e starts at e*base plus the longer edges before it
			start_q[1] <= W'(base_q + ((extra_q > 3'd0) ? W'(1) : W'(0)));
			start_q[2] <= W'((base_q << 1) + ((extra_q > 3'd1) ? W'(2) : W'(extra_q)));
			start_q[3] <= W'((base_q << 1) + base_q +
				((extra_q > 3'd2) ? W'(3) : W'(extra_q)));
			start_q[4] <= W'((base_q << 2) + ((extra_q > 3'd3) ? W'(4) : W'(extra_q)));
		end
	end

	assign busy = (su_q != ccep_pkg::SU_IDLE);

	// stage 1: range checks and edge search
	logic         acc;
	logic         vld_s1, small_s1, last_s1;
	logic [1:0]   status_s1;
	logic [2:0]   edge_s1;
	logic [W-1:0] idx_s1;
	logic [2:0]   edge_c;
	logic [ccep_pkg::CNT_W-1:0] idx_ext;

	assign acc     = start && !busy;
	assign idx_ext = ccep_pkg::CNT_W'(palette_index);
	assign edge_c  = 3'(palette_index >= start_q[1]) + 3'(palette_index >= start_q[2]) +
		3'(palette_index >= start_q[3]) + 3'(palette_index >= start_q[4]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= acc;
	end

	always_ff @(posedge clk) begin
		idx_s1    <= palette_index;
		small_s1  <= cnt < ccep_pkg::SMALL_LIMIT;
		last_s1   <= idx_ext == (cnt - 13'd1);
		edge_s1   <= edge_c;
		if (cnt == '0)          status_s1 <= ccep_pkg::ST_EMPTY;
		else if (idx_ext >= cnt) status_s1 <= ccep_pkg::ST_RANGE;
		else                    status_s1 <= ccep_pkg::ST_OK;
	end

	// stage 2: offset along the edge, step select, fixed table
	logic          vld_s2, small_s2, last_s2;
	logic [1:0]    status_s2;
	logic [2:0]    edge_s2;
	logic [W-1:0]  pos_s2, step_s2;
	ccep_pkg::rgb_t small_s2_rgb;
	logic [W-1:0]  edge_base;

	always_comb begin
		case (edge_s1)
			ccep_pkg::EDGE_YG: edge_base = start_q[1];
			ccep_pkg::EDGE_GC: edge_base = start_q[2];
			ccep_pkg::EDGE_CB: edge_base = start_q[3];
			ccep_pkg::EDGE_BM: edge_base = start_q[4];
			default:           edge_base = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		small_s2     <= small_s1;
		last_s2      <= last_s1;
		status_s2    <= status_s1;
		edge_s2      <= edge_s1;
		pos_s2       <= W'(idx_s1 - edge_base);
		step_s2      <= (edge_s1 < extra_q) ? step_long_q : step_short_q;
		small_s2_rgb <= ccep_pkg::small_color(idx_s1[3:0]);
	end

	// stage 3: distance from the start corner
	logic           vld_s3, small_s3, last_s3;
	logic [1:0]     status_s3;
	logic [2:0]     edge_s3;
	logic [W-1:0]   prod_s3;
	logic [2*W-1:0] prod;
	ccep_pkg::rgb_t small_s3_rgb;

	assign prod = step_s2 * pos_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		small_s3     <= small_s2;
		last_s3      <= last_s2;
		status_s3    <= status_s2;
		edge_s3      <= edge_s2;
		prod_s3      <= prod[W-1:0];
		small_s3_rgb <= small_s2_rgb;
	end

	// stage 4: corner compose into the output register
	ccep_pkg::rgb_t cube, pick;
	logic           vld_q;
	ccep_pkg::rgb_t out_q;
	logic [1:0]     status_q;

	always_comb begin
		case (edge_s3)
			ccep_pkg::EDGE_RY: cube = '{lvl, prod_s3, W'(0)};
			ccep_pkg::EDGE_YG: cube = '{W'(lvl - prod_s3), lvl, W'(0)};
			ccep_pkg::EDGE_GC: cube = '{W'(0), lvl, prod_s3};
			ccep_pkg::EDGE_CB: cube = '{W'(0), W'(lvl - prod_s3), lvl};
			default:           cube = '{prod_s3, W'(0), lvl};
		endcase
		if (status_s3 != ccep_pkg::ST_OK) pick = '{W'(0), W'(0), W'(0)};
		else if (small_s3)                pick = small_s3_rgb;
		else if (last_s3)                 pick = '{lvl, W'(0), lvl};
		else                              pick = cube;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else         vld_q <= vld_s3;
	end

	always_ff @(posedge clk) begin
		out_q    <= pick;
		status_q <= status_s3;
	end

	assign result_valid = vld_q;
	assign red          = out_q.r;
	assign green        = out_q.g;
	assign blue         = out_q.b;
	assign status       = status_q;
endmodule

[hdl/ccep_checker.sv]
// port-level checks for the color cube edge palette unit, bound to the top level
// depends on ccep_pkg and assert_macros.svh
`include "assert_macros.svh"

module ccep_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_valid,
	input logic [11:0] red,
	input logic [11:0] green,
	input logic [11:0] blue,
	input logic [1:0]  status,
	input logic        cfg_we
);
	// every item taken gives a result
	`CCEP_ASSERT(a_latency, clk, arst_n, (start && !busy) |-> ##4 result_valid)
	// no result without an item taken before it
	`CCEP_ASSERT(a_no_extra, clk, arst_n, result_valid |-> $past(start && !busy, 4))
	// error results carry black
	`CCEP_ASSERT(a_err_black, clk, arst_n,
		(result_valid && status != ccep_pkg::ST_OK) |-> (red == '0 && green == '0 && blue == '0))
	// a register write starts a new setup pass
	`CCEP_ASSERT(a_cfg_busy, clk, arst_n, cfg_we |=> busy)
endmodule

bind color_cube_edge_palette_unit ccep_checker u_ccep_checker (.*);

[bench/tb_color_cube_edge_palette_unit.sv]
// self-checking bench for the color cube edge palette unit
// depends on ccep_pkg and the unit's rtl; predicts each entry and checks every result
`timescale 1ns / 1ps

class palette_scoreboard;
	typedef struct {
		logic [11:0] r;
		logic [11:0] g;
		logic [11:0] b;
		ccep_pkg::status_t st;
	} color_t;

	color_t pending[$];
	int errors = 0;
	logic [11:0] level = 12'd255;
	logic [12:0] colors = 13'd10;

	function void set_reg(ccep_pkg::reg_idx_t idx, logic [12:0] data);
		if (idx == ccep_pkg::REG_MAX_LEVEL)
			level = data[11:0];
		else
			colors = data;
	endfunction

	function color_t predict(logic [11:0] idx);
		color_t c;
		int unsigned cnt, lvl, span, base, extra, long_part, edge_n, pos, len, stp;
		int unsigned ch[3];
		logic [11:0] sr[10] = '{215, 255, 44, 0, 192, 194, 166, 171, 166, 235};
		logic [11:0] sg[10] = '{25, 255, 123, 136, 192, 165, 97, 217, 219, 150};
		logic [11:0] sb[10] = '{28, 191, 182, 55, 192, 207, 26, 233, 160, 5};
		bit cr[5] = '{1, 1, 0, 0, 0};
		bit cg[5] = '{0, 1, 1, 1, 0};
		bit cb[5] = '{0, 0, 0, 1, 1};
		int mch[5] = '{1, 0, 2, 1, 0};
		bit mup[5] = '{1, 0, 1, 0, 1};
		cnt = (colors > 4096) ? 4096 : colors;
		lvl = level;
		ch = '{0, 0, 0};
		c.st = ccep_pkg::ST_OK;
		if (cnt == 0)
			c.st = ccep_pkg::ST_EMPTY;
		else if (idx >= cnt)
			c.st = ccep_pkg::ST_RANGE;
		else if (cnt < 10)
			ch = '{sr[idx], sg[idx], sb[idx]};
		else if (idx == cnt - 1)
			ch = '{lvl, 0, lvl};
		else begin
			span = cnt - 1;
			base = span / 5;
			extra = span % 5;
			long_part = extra * (base + 1);
			if (idx < long_part) begin
				edge_n = idx / (base + 1);
				pos = idx % (base + 1);
				len = base + 1;
			end else begin
				edge_n = extra + (idx - long_part) / base;
				pos = (idx - long_part) % base;
				len = base;
			end
			if (edge_n > 4)
				edge_n = 4;
			stp = lvl / len;
			ch = '{cr[edge_n] ? lvl : 0, cg[edge_n] ? lvl : 0, cb[edge_n] ? lvl : 0};
			if (mup[edge_n])
				ch[mch[edge_n]] = ch[mch[edge_n]] + stp * pos;
			else
				ch[mch[edge_n]] = ch[mch[edge_n]] - stp * pos;
		end
		c.r = ch[0][11:0];
		c.g = ch[1][11:0];
		c.b = ch[2][11:0];
		return c;
	endfunction

	function void note_index(logic [11:0] idx);
		pending.push_back(predict(idx));
	endfunction

	function void check_color(logic [11:0] r, logic [11:0] g, logic [11:0] b, logic [1:0] st);
		color_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result r=%0d g=%0d b=%0d st=%0d", $time, r, g, b, st);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (r !== e.r || g !== e.g || b !== e.b || st !== e.st) begin
			$display("%0t: mismatch expected r=%0d g=%0d b=%0d st=%0d actual r=%0d g=%0d b=%0d st=%0d",
				$time, e.r, e.g, e.b, e.st, r, g, b, st);
			errors++;
		end
	endfunction
endclass

module tb_color_cube_edge_palette_unit;
	logic clk, arst_n, start, busy, result_valid, cfg_we;
	logic [11:0] palette_index, red, green, blue;
	logic [1:0] status;
	logic [0:0] cfg_index;
	logic [12:0] cfg_data;
	palette_scoreboard sb;
	int cycles = 0;
	bit no_gaps = 0;

	color_cube_edge_palette_unit u_dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && result_valid)
			sb.check_color(red, green, blue, status);

	task automatic send_index(logic [11:0] idx);
		int gap;
		if (!no_gaps && $urandom_range(3) == 0) begin
			gap = $urandom_range(1, 11);
			start <= 0;
			repeat (gap) @(negedge clk);
		end
		start <= 1;
		palette_index <= idx;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_index(idx);
		@(negedge clk);
	endtask

	task automatic write_reg(ccep_pkg::reg_idx_t idx, logic [12:0] data);
		start <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// random index, mostly inside the palette
	function automatic logic [11:0] pick_index(logic [12:0] n);
		if (n != 0 && $urandom_range(9) < 8)
			return 12'($urandom_range((n > 4096 ? 4096 : n) - 1));
		return 12'($urandom_range(4095));
	endfunction

	initial begin
		logic [12:0] n;
		logic [11:0] lv;
		sb = new();
		start = 0; palette_index = 0; cfg_we = 0;
		cfg_index = ccep_pkg::REG_MAX_LEVEL; cfg_data = 0;
		arst_n = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		// reset palette: all ten entries and past the end
		for (int i = 0; i < 12; i++) send_index(i[11:0]);
		send_index(12'hFFF);
		write_reg(ccep_pkg::REG_NUM_COLORS, 13'd9);
		for (int i = 0; i < 9; i++) send_index(i[11:0]);
		write_reg(ccep_pkg::REG_NUM_COLORS, 13'd0);
		send_index(12'd0);
		send_index(12'hFFF);
		write_reg(ccep_pkg::REG_NUM_COLORS, 13'h1FFF);
		write_reg(ccep_pkg::REG_MAX_LEVEL, 13'd4095);
		send_index(12'd0); send_index(12'd2047); send_index(12'd4094); send_index(12'd4095);
		write_reg(ccep_pkg::REG_MAX_LEVEL, 13'd0);
		send_index(12'd1000); send_index(12'd4095);
		for (int ph = 0; ph < 32; ph++) begin
			case (ph % 4)
				0: n = 13'($urandom_range(1, 30));
				1: n = 13'($urandom_range(0, 8191));
				2: n = 13'($urandom_range(9, 200));
				default: n = (ph % 8 == 3) ? 13'd4096 : 13'd10;
			endcase
			lv = (ph % 5 == 0) ? 12'd4095 : (ph % 7 == 0) ? 12'd1 :
				12'($urandom_range(0, 4095));
			write_reg(ccep_pkg::REG_NUM_COLORS, n);
			write_reg(ccep_pkg::REG_MAX_LEVEL, {1'b0, lv});
			if (ph >= 28) no_gaps = 1;
			for (int i = 0; i < 50; i++) send_index(pick_index(n));
		end
		start <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
